### src/lsvm_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and saturation helpers for the linear SVM block.
// Used by lsvm_ram's users, the top level and the checker; depends on nothing.
package lsvm_pkg;

  localparam int MaxFeatures   = 16;
  localparam int MaxSamples    = 1024;
  localparam int FeatIdxBits   = 4;
  localparam int SampleIdxBits = 10;
  localparam int StoreDepth    = MaxSamples * MaxFeatures;

  typedef enum logic [1:0] {
    KIND_WEIGHT   = 2'd0,
    KIND_BIAS     = 2'd1,
    KIND_DECISION = 2'd2
  } out_kind_e;

  localparam logic [2:0] CFG_MODE    = 3'd0;
  localparam logic [2:0] CFG_RATE    = 3'd1;
  localparam logic [2:0] CFG_PENALTY = 3'd2;
  localparam logic [2:0] CFG_EPOCHS  = 3'd3;
  localparam logic [2:0] CFG_FEAT    = 3'd4;

  localparam logic MODE_TRAIN    = 1'b0;
  localparam logic MODE_CLASSIFY = 1'b1;

  function automatic logic signed [31:0] sat_weight(input logic signed [52:0] v);
    if (v > 53'sd2147483647) return 32'sh7fffffff;
    else if (v < -53'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic signed [47:0] sat_acc(input logic signed [52:0] v);
    if (v > 53'sd140737488355327) return 48'sh7fffffffffff;
    else if (v < -53'sd140737488355328) return 48'sh800000000000;
    else return v[47:0];
  endfunction

endpackage

### src/lsvm_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module lsvm_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### src/linear_svm_trainer_classifier_unit.sv
`timescale 1ns / 1ps
// Linear SVM: loads one feature word per cycle when idle, trains by hinge-loss SGD, classifies.
// Depends on lsvm_pkg and lsvm_ram; one shared 35x17 multiplier serves all multiplications.
// Load: one word per cycle when idle; a sample end zero-fills the row's remaining store words.
// Training: per sample and epoch, dot product, hinge test, weight updates, and a bias update
// if the margin is below one; then nf + 1 result words. Classify: per-word MAC, then decision.
// Reset is asynchronous: weights, bias, counters and control registers take their defaults.
module linear_svm_trainer_classifier_unit
  import lsvm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] feature_i,
  input  logic               label_positive_i,
  input  logic               sample_end_i,
  input  logic               set_end_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         out_kind_o,
  output logic [3:0]         out_index_o,
  output logic signed [31:0] out_value_o,
  output logic               out_last_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_ZFILL, S_TINIT, S_SAMPLE, S_DWAIT, S_DMUL, S_DACC, S_HINGE,
    S_UWAIT, S_UMULC, S_UG, S_UMULL, S_UUPD, S_BMUL, S_BUPD, S_NEXT,
    S_EMIT, S_CMUL, S_CACC, S_CFIN
  } state_e;

  state_e state_q;
  logic        mode_q;
  logic [15:0] rate_q, penalty_q;
  logic [9:0]  epochs_q;
  logic [4:0]  feat_cfg_q;

  logic signed [31:0] w_q [MaxFeatures];
  logic signed [31:0] bias_q;
  logic signed [47:0] acc_q;
  logic signed [51:0] prod_q;
  logic signed [34:0] g_q;
  logic signed [15:0] x_q;
  logic [10:0] total_q, i_q;
  logic [9:0]  e_q;
  logic [4:0]  fp_q, j_q;
  logic [SampleIdxBits-1:0] row_q;
  logic hinge_q, tend_q, send_q;
  logic out_valid_q, out_last_q;
  logic [1:0] out_kind_q;
  logic [3:0] out_index_q;
  logic signed [31:0] out_value_q;

  logic [4:0] nf;
  logic in_acc, cfg_acc, store_full, out_free, y;
  logic sram_we, lram_we;
  logic [SampleIdxBits+FeatIdxBits-1:0] sram_waddr, sram_raddr;
  logic [15:0] sram_wdata, sram_rdata;
  logic [0:0] lram_rdata;
  logic signed [34:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [51:0] prod_d, cneg, crnd, rnd16, bneg, brnd;
  logic signed [52:0] w_new, b_new, acc_sum;
  logic signed [48:0] score;
  logic signed [34:0] g_d;
  logic signed [31:0] w_j;

  assign nf = (feat_cfg_q == 5'd0) ? 5'd1 :
              (feat_cfg_q > 5'(MaxFeatures)) ? 5'(MaxFeatures) : feat_cfg_q;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc  = in_valid_i && in_ready_o;
  assign cfg_acc = cfg_valid_i && cfg_ready_o;
  assign store_full = total_q[10];
  assign out_free = !out_valid_q || out_ready_i;
  assign y = lram_rdata[0];
  assign w_j = (state_q == S_CMUL) ? w_q[fp_q[3:0]] : w_q[j_q[3:0]];

  // Store write port: live feature words, or zero fill after a short sample.
  always_comb begin
    if (state_q == S_ZFILL) begin
      sram_we    = !j_q[4];
      sram_waddr = {row_q, j_q[3:0]};
      sram_wdata = '0;
    end else begin
      sram_we    = in_acc && (mode_q == MODE_TRAIN) && !store_full && (fp_q < nf);
      sram_waddr = {total_q[SampleIdxBits-1:0], fp_q[3:0]};
      sram_wdata = feature_i;
    end
  end
  assign lram_we = in_acc && (mode_q == MODE_TRAIN) && (sample_end_i || set_end_i) && !store_full;
  assign sram_raddr = {i_q[SampleIdxBits-1:0], j_q[3:0]};

  lsvm_ram #(.Width(16), .Depth(StoreDepth)) u_sample_ram (
    .clk_i(clk_i), .we_i(sram_we), .waddr_i(sram_waddr), .wdata_i(sram_wdata),
    .raddr_i(sram_raddr), .rdata_o(sram_rdata)
  );

  lsvm_ram #(.Width(1), .Depth(MaxSamples)) u_label_ram (
    .clk_i(clk_i), .we_i(lram_we), .waddr_i(total_q[SampleIdxBits-1:0]),
    .wdata_i(label_positive_i), .raddr_i(i_q[SampleIdxBits-1:0]), .rdata_o(lram_rdata)
  );

  // Shared multiplier operand selection.
  always_comb begin
    case (state_q)
      S_DMUL: begin
        mul_a = 35'(w_j);
        mul_b = 17'($signed(sram_rdata));
      end
      S_UMULC: begin
        mul_a = 35'($signed(sram_rdata));
        mul_b = $signed({1'b0, penalty_q});
      end
      S_UMULL: begin
        mul_a = g_q;
        mul_b = $signed({1'b0, rate_q});
      end
      S_BMUL: begin
        mul_a = $signed({19'b0, rate_q});
        mul_b = $signed({1'b0, penalty_q});
      end
      S_CMUL: begin
        mul_a = 35'(w_j);
        mul_b = 17'(x_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = mul_a * mul_b;
  end

  // Update arithmetic, fed from the registered product, accumulator, weights and bias.
  always_comb begin
    cneg    = y ? prod_q : -prod_q;
    crnd    = (cneg + 52'sd8) >>> 4;
    g_d     = 35'(w_j) - (hinge_q ? crnd[34:0] : 35'sd0);
    rnd16   = (prod_q + 52'sd32768) >>> 16;
    w_new   = 53'(w_j) - 53'(rnd16);
    bneg    = y ? prod_q : -prod_q;
    brnd    = (bneg + 52'sd128) >>> 8;
    b_new   = 53'(bias_q) + 53'(brnd);
    acc_sum = 53'(acc_q) + 53'(prod_q);
    score   = 49'(acc_q) + 49'($signed({bias_q, 12'b0}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_TRAIN;
      rate_q      <= 16'd655;
      penalty_q   <= 16'd256;
      epochs_q    <= 10'd100;
      feat_cfg_q  <= 5'd16;
      for (int k = 0; k < MaxFeatures; k++) w_q[k] <= '0;
      bias_q      <= '0;
      acc_q       <= '0;
      total_q     <= '0;
      i_q         <= '0;
      e_q         <= '0;
      fp_q        <= '0;
      j_q         <= '0;
      hinge_q     <= 1'b0;
      tend_q      <= 1'b0;
      send_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_kind_q  <= KIND_WEIGHT;
      out_index_q <= '0;
    end else begin
      // The emitting states load the next word themselves whenever the slot frees up.
      if (out_ready_i && state_q != S_EMIT && state_q != S_CFIN) out_valid_q <= 1'b0;

      if (cfg_acc) begin
        case (cfg_index_i)
          CFG_MODE: begin
            mode_q <= cfg_data_i[0];
            fp_q   <= '0;
            acc_q  <= '0;
          end
          CFG_RATE:    rate_q     <= cfg_data_i;
          CFG_PENALTY: penalty_q  <= cfg_data_i;
          CFG_EPOCHS:  epochs_q   <= cfg_data_i[9:0];
          CFG_FEAT:    feat_cfg_q <= cfg_data_i[4:0];
          default: ;
        endcase
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (mode_q == MODE_TRAIN) begin
              if (sample_end_i || set_end_i) begin
                fp_q <= '0;
                if (!store_full) begin
                  row_q   <= total_q[SampleIdxBits-1:0];
                  total_q <= total_q + 11'd1;
                  j_q     <= (fp_q < nf) ? fp_q + 5'd1 : fp_q;
                  tend_q  <= set_end_i;
                  state_q <= S_ZFILL;
                end else if (set_end_i) begin
                  state_q <= S_TINIT;
                end
              end else if (!store_full && fp_q < nf) begin
                fp_q <= fp_q + 5'd1;
              end
            end else begin
              x_q    <= feature_i;
              send_q <= sample_end_i;
              if (fp_q < nf) state_q <= S_CMUL;
              else if (sample_end_i) state_q <= S_CFIN;
            end
          end
        end
        S_ZFILL: begin
          if (j_q[4]) state_q <= tend_q ? S_TINIT : S_IDLE;
          else j_q <= j_q + 5'd1;
        end
        S_TINIT: begin
          for (int k = 0; k < MaxFeatures; k++) w_q[k] <= '0;
          bias_q <= '0;
          i_q <= '0;
          e_q <= '0;
          j_q <= '0;
          state_q <= (epochs_q == 10'd0 || total_q == 11'd0) ? S_EMIT : S_SAMPLE;
        end
        S_SAMPLE: begin
          acc_q   <= 48'($signed({bias_q, 12'b0}));
          j_q     <= '0;
          state_q <= S_DWAIT;
        end
        S_DWAIT: state_q <= S_DMUL;
        S_DMUL: begin
          prod_q  <= prod_d;
          state_q <= S_DACC;
        end
        S_DACC: begin
          acc_q <= sat_acc(acc_sum);
          if (j_q + 5'd1 == nf) begin
            j_q     <= '0;
            state_q <= S_HINGE;
          end else begin
            j_q     <= j_q + 5'd1;
            state_q <= S_DWAIT;
          end
        end
        S_HINGE: begin
          // Margin below one in Q.28: y*acc < 2^28.
          hinge_q <= y ? (acc_q < 48'sd268435456) : (acc_q > -48'sd268435456);
          state_q <= S_UWAIT;
        end
        S_UWAIT: state_q <= S_UMULC;
        S_UMULC: begin
          prod_q  <= prod_d;
          state_q <= S_UG;
        end
        S_UG: begin
          g_q     <= g_d;
          state_q <= S_UMULL;
        end
        S_UMULL: begin
          prod_q  <= prod_d;
          state_q <= S_UUPD;
        end
        S_UUPD: begin
          w_q[j_q[3:0]] <= sat_weight(w_new);
          if (j_q + 5'd1 == nf) begin
            j_q     <= '0;
            state_q <= hinge_q ? S_BMUL : S_NEXT;
          end else begin
            j_q     <= j_q + 5'd1;
            state_q <= S_UWAIT;
          end
        end
        S_BMUL: begin
          prod_q  <= prod_d;
          state_q <= S_BUPD;
        end
        S_BUPD: begin
          bias_q  <= sat_weight(b_new);
          state_q <= S_NEXT;
        end
        S_NEXT: begin
          if (i_q + 11'd1 == total_q) begin
            i_q <= '0;
            if (11'(e_q) + 11'd1 == 11'(epochs_q)) begin
              j_q     <= '0;
              state_q <= S_EMIT;
            end else begin
              e_q     <= e_q + 10'd1;
              state_q <= S_SAMPLE;
            end
          end else begin
            i_q     <= i_q + 11'd1;
            state_q <= S_SAMPLE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            if (j_q == nf) begin
              out_kind_q  <= KIND_BIAS;
              out_index_q <= '0;
              out_value_q <= bias_q;
              out_last_q  <= 1'b1;
              total_q     <= '0;
              fp_q        <= '0;
              state_q     <= S_IDLE;
            end else begin
              out_kind_q  <= KIND_WEIGHT;
              out_index_q <= j_q[3:0];
              out_value_q <= w_j;
              out_last_q  <= 1'b0;
              j_q         <= j_q + 5'd1;
            end
          end
        end
        S_CMUL: begin
          prod_q  <= prod_d;
          state_q <= S_CACC;
        end
        S_CACC: begin
          acc_q   <= sat_acc(acc_sum);
          fp_q    <= fp_q + 5'd1;
          state_q <= send_q ? S_CFIN : S_IDLE;
        end
        S_CFIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= KIND_DECISION;
            out_index_q <= '0;
            out_value_q <= score[48] ? -32'sd1 : 32'sd1;
            out_last_q  <= 1'b1;
            fp_q        <= '0;
            acc_q       <= '0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_index_o = out_index_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

endmodule

### src/lsvm_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the linear SVM unit, bound to the top level.
// Depends on lsvm_pkg for the result kind codes.
module lsvm_checker
  import lsvm_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [1:0]         out_kind_o,
  input logic [3:0]         out_index_o,
  input logic signed [31:0] out_value_o,
  input logic               out_last_o
);

  // A decision word is always +1 or -1 and closes its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KIND_DECISION |->
      out_last_o && (out_value_o == 32'sd1 || out_value_o == -32'sd1))
    else $error("bad decision word");

  // The bias word closes a training run and carries index zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KIND_BIAS |-> out_last_o && out_index_o == 4'd0)
    else $error("bad bias word");

  // While weights are being emitted no new input is taken, and no weight word is marked last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KIND_WEIGHT |-> !in_ready_o && !out_last_o)
    else $error("input taken during weight dump");

  // A weight taken is followed by another weight or the bias, never a decision.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_kind_o == KIND_WEIGHT ##1 out_valid_o |->
      out_kind_o != KIND_DECISION)
    else $error("weight dump interrupted");

  // The kind field never shows the unused code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_kind_o != 2'd3)
    else $error("unused result kind");

endmodule

bind linear_svm_trainer_classifier_unit lsvm_checker u_lsvm_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_ready_o(in_ready_o), .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i), .out_kind_o(out_kind_o), .out_index_o(out_index_o),
  .out_value_o(out_value_o), .out_last_o(out_last_o)
);
